// ===== hdl/lat_pkg.sv =====
// Shared types, constants and codes for the logic analyzer trigger capture.
package lat_pkg;

  localparam int unsigned CaptureDepth = 1024;
  localparam int unsigned PreSamples   = 511;
  localparam int unsigned PostSamples  = 512;

  localparam int unsigned AddrW   = $clog2(CaptureDepth);
  localparam int unsigned PreW    = $clog2(PreSamples + 1);
  localparam int unsigned PostW   = $clog2(PostSamples + 1);
  localparam int unsigned SampleW = 8;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned EdgeW   = 3;
  localparam int unsigned SumW    = ((AddrW > IndexW) ? AddrW : IndexW) + 1;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } lat_cmd_e;

  typedef enum logic [1:0] {
    PH_PREFILL = 2'd0,
    PH_ARMED   = 2'd1,
    PH_POST    = 2'd2,
    PH_DONE    = 2'd3
  } lat_phase_e;

  typedef enum logic [ModeW-1:0] {
    TRIG_OFF     = 2'd0,
    TRIG_PATTERN = 2'd1,
    TRIG_RISE    = 2'd2,
    TRIG_FALL    = 2'd3
  } lat_trig_e;

  typedef enum logic [1:0] {
    REG_TRIGGER_MODE  = 2'd0,
    REG_MATCH_PATTERN = 2'd1,
    REG_MATCH_MASK    = 2'd2,
    REG_EDGE_BIT      = 2'd3
  } lat_reg_e;

  typedef struct packed {
    logic [ModeW-1:0]   trigger_mode;
    logic [SampleW-1:0] match_pattern;
    logic [SampleW-1:0] match_mask;
    logic [EdgeW-1:0]   edge_bit;
  } lat_cfg_t;

  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [SampleW-1:0] wdata;
    logic               re;
    logic [AddrW-1:0]   raddr;
  } lat_mem_req_t;

  typedef struct packed {
    logic fired;
    logic rd_ok;
    logic is_armed;
    logic is_done;
  } lat_res_t;

endpackage

// ===== hdl/lat_if.sv =====
// Valid/ready channel interfaces for the capture input and result streams.
interface lat_in_if;
  import lat_pkg::*;
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [SampleW-1:0] sample_in;
  logic [IndexW-1:0]  read_index;

  modport source (output valid, command, sample_in, read_index, input ready);
  modport sink   (input valid, command, sample_in, read_index, output ready);
endinterface

interface lat_out_if;
  import lat_pkg::*;
  logic               valid;
  logic               ready;
  logic               fired;
  logic [SampleW-1:0] read_data;
  logic               is_armed;
  logic               is_done;

  modport source (output valid, fired, read_data, is_armed, is_done, input ready);
  modport sink   (input valid, fired, read_data, is_armed, is_done, output ready);
endinterface

// ===== hdl/lat_cfg.sv =====
// APB register file for trigger mode, match pattern, match mask and edge bit.
module lat_cfg
  import lat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output lat_cfg_t            cfg_o
);

  lat_cfg_t cfg_q;
  lat_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = lat_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TRIGGER_MODE:  cfg_q.trigger_mode  <= pwdata[ModeW-1:0];
        REG_MATCH_PATTERN: cfg_q.match_pattern <= pwdata[SampleW-1:0];
        REG_MATCH_MASK:    cfg_q.match_mask    <= pwdata[SampleW-1:0];
        REG_EDGE_BIT:      cfg_q.edge_bit      <= pwdata[EdgeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TRIGGER_MODE:  prdata = CfgDataW'(cfg_q.trigger_mode);
      REG_MATCH_PATTERN: prdata = CfgDataW'(cfg_q.match_pattern);
      REG_MATCH_MASK:    prdata = CfgDataW'(cfg_q.match_mask);
      REG_EDGE_BIT:      prdata = CfgDataW'(cfg_q.edge_bit);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lat_ram.sv =====
// Sample ring storage: one write port, one registered read port.
module lat_ram
  import lat_pkg::*;
(
  input  logic               clk_i,
  input  lat_mem_req_t       req_i,
  output logic [SampleW-1:0] rdata_o
);

  logic [SampleW-1:0] mem [CaptureDepth];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lat_core.sv =====
// Capture phase sequencer, trigger logic and ring addressing.
module lat_core
  import lat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [IndexW-1:0]  index_i,
  input  lat_cfg_t           cfg_i,
  output lat_mem_req_t       mem_req_o,
  output lat_res_t           res_o
);

  lat_phase_e         phase_q, phase_d;
  logic [AddrW-1:0]   wpos_q, wpos_d;
  logic [AddrW-1:0]   start_q, start_d;
  logic [PreW-1:0]    pre_q, pre_d;
  logic [PostW-1:0]   post_q, post_d;
  logic [SampleW-1:0] last_sample_q, last_sample_d;
  logic               last_match_q, last_match_d;
  logic               base_ok_q, base_ok_d;

  logic [AddrW-1:0]   wpos_inc;
  logic [PostW-1:0]   post_dec;
  logic [SumW-1:0]    rd_sum;
  logic [SumW-1:0]    rd_wrap;
  logic               pat_hit;
  logic               prev_bit;
  logic               cur_bit;
  logic               fire;

  assign wpos_inc = (wpos_q == AddrW'(CaptureDepth - 1)) ? '0 : wpos_q + 1'b1;
  assign post_dec = (post_q != '0) ? post_q - 1'b1 : post_q;
  assign rd_sum   = SumW'(start_q) + SumW'(index_i);
  assign rd_wrap  = (rd_sum >= SumW'(CaptureDepth)) ? rd_sum - SumW'(CaptureDepth) : rd_sum;
  assign pat_hit  = (cfg_i.match_mask != '0) &&
                    ((sample_i & cfg_i.match_mask) ==
                     (cfg_i.match_pattern & cfg_i.match_mask));
  assign prev_bit = last_sample_q[cfg_i.edge_bit];
  assign cur_bit  = sample_i[cfg_i.edge_bit];

  always_comb begin
    phase_d       = phase_q;
    wpos_d        = wpos_q;
    start_d       = start_q;
    pre_d         = pre_q;
    post_d        = post_q;
    last_sample_d = last_sample_q;
    last_match_d  = last_match_q;
    base_ok_d     = base_ok_q;
    fire          = 1'b0;
    mem_req_o       = '0;
    mem_req_o.waddr = wpos_q;
    mem_req_o.wdata = sample_i;
    mem_req_o.raddr = rd_wrap[AddrW-1:0];
    res_o         = '0;

    if (adv_i) begin
      mem_req_o.re = 1'b1;
      unique case (lat_cmd_e'(command_i))
        CMD_OBSERVE: begin
          if (phase_q != PH_DONE) begin
            mem_req_o.we = 1'b1;
            wpos_d       = wpos_inc;
          end
          unique case (phase_q)
            PH_PREFILL: begin
              pre_d = pre_q + 1'b1;
              if (pre_d >= PreW'(PreSamples)) begin
                last_sample_d = '0;
                last_match_d  = 1'b0;
                base_ok_d     = 1'b0;
                phase_d       = PH_ARMED;
              end
            end
            PH_ARMED: begin
              unique case (lat_trig_e'(cfg_i.trigger_mode))
                TRIG_OFF: ;
                TRIG_PATTERN: begin
                  fire         = pat_hit && !last_match_q;
                  last_match_d = pat_hit;
                end
                TRIG_RISE: begin
                  fire          = base_ok_q && !prev_bit && cur_bit;
                  base_ok_d     = 1'b1;
                  last_sample_d = sample_i;
                end
                TRIG_FALL: begin
                  fire          = base_ok_q && prev_bit && !cur_bit;
                  base_ok_d     = 1'b1;
                  last_sample_d = sample_i;
                end
                default: ;
              endcase
              if (fire) begin
                post_d  = PostW'(PostSamples);
                phase_d = PH_POST;
              end
            end
            PH_POST: begin
              post_d = post_dec;
              if (post_dec == '0) begin
                start_d = wpos_inc;
                phase_d = PH_DONE;
              end
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          res_o.rd_ok = (phase_q == PH_DONE);
        end
        CMD_RESTART: begin
          phase_d       = PH_PREFILL;
          wpos_d        = '0;
          start_d       = '0;
          pre_d         = '0;
          post_d        = '0;
          last_sample_d = '0;
          last_match_d  = 1'b0;
          base_ok_d     = 1'b0;
        end
        default: ;
      endcase
    end

    res_o.fired    = fire;
    res_o.is_armed = (phase_d == PH_ARMED);
    res_o.is_done  = (phase_d == PH_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_PREFILL;
      wpos_q        <= '0;
      start_q       <= '0;
      pre_q         <= '0;
      post_q        <= '0;
      last_sample_q <= '0;
      last_match_q  <= 1'b0;
      base_ok_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      wpos_q        <= wpos_d;
      start_q       <= start_d;
      pre_q         <= pre_d;
      post_q        <= post_d;
      last_sample_q <= last_sample_d;
      last_match_q  <= last_match_d;
      base_ok_q     <= base_ok_d;
    end
  end

endmodule

// ===== hdl/logic_analyzer_trigger_capture.sv =====
// A transaction passes the input stage and then the output register before its result leaves.
// Throughput: one transaction per cycle, set by the single write and read port of
// the sample ring; both stages advance together whenever the output is free.
// Reset (rst_ni low, asynchronous): phase to prefill, counters and positions to zero,
// config registers to zero, both pipeline stages empty. Ring contents are not cleared.
module logic_analyzer_trigger_capture
  import lat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  lat_in_if.sink              in_i,
  lat_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Input stage: holds one accepted transaction.
  logic               s1_valid_q;
  logic [CmdW-1:0]    s1_cmd_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [IndexW-1:0]  s1_index_q;

  // Result stage: read data register lives in the ring.
  logic               s2_valid_q;
  lat_res_t           s2_res_q;

  lat_cfg_t           cfg;
  lat_mem_req_t       mem_req;
  lat_res_t           res;
  logic [SampleW-1:0] ram_rdata;
  logic               adv;
  logic               take;

  // Advance the input stage into the result stage when the result slot is free.
  assign adv        = s1_valid_q && (!s2_valid_q || out_o.ready);
  // Take a new transaction when the input stage empties or drains this cycle.
  assign in_i.ready = !s1_valid_q || adv;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q    <= in_i.command;
      s1_sample_q <= in_i.sample_in;
      s1_index_q  <= in_i.read_index;
    end
  end

  lat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Phase sequencing, trigger test and ring addressing all happen on advance.
  lat_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .command_i (s1_cmd_q),
    .sample_i  (s1_sample_q),
    .index_i   (s1_index_q),
    .cfg_i     (cfg),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  // Read data is captured on the same edge as the result flags and holds on stall.
  lat_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || out_o.ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_res_q <= res;
    end
  end

  assign out_o.valid     = s2_valid_q;
  assign out_o.fired     = s2_res_q.fired;
  // Drop read data to zero unless this was a read after the capture finished.
  assign out_o.read_data = s2_res_q.rd_ok ? ram_rdata : '0;
  assign out_o.is_armed  = s2_res_q.is_armed;
  assign out_o.is_done   = s2_res_q.is_done;

endmodule

// ===== hdl/lat_checker.sv =====
// Port-level checks on the capture result stream, bound to the top level.
module lat_checker
  import lat_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               fired_i,
  input logic [SampleW-1:0] read_data_i,
  input logic               is_armed_i,
  input logic               is_done_i
);

  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(is_armed_i && is_done_i))
    else $error("armed and done shown together");

  a_fire_leaves_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && fired_i) |-> (!is_armed_i && !is_done_i))
    else $error("trigger did not move capture into post phase");

  a_data_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (read_data_i != '0)) |-> (is_done_i && !fired_i))
    else $error("read data shown outside a finished capture");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(fired_i) && $stable(read_data_i) &&
       $stable(is_armed_i) && $stable(is_done_i)))
    else $error("result changed while stalled");

endmodule

bind logic_analyzer_trigger_capture lat_checker u_lat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .fired_i     (out_o.fired),
  .read_data_i (out_o.read_data),
  .is_armed_i  (out_o.is_armed),
  .is_done_i   (out_o.is_done)
);

// ===== dv/lat_capture_sb_pkg.sv =====
// Scoreboard for the trigger capture: capture predictor and queue of predicted readouts.
package lat_capture_sb_pkg;
  import lat_pkg::*;

  // Command code 3 has no meaning and leaves the capture alone.
  localparam logic [CmdW-1:0] CmdNoOp = 2'd3;

  typedef struct packed {
    logic               fired;
    logic [SampleW-1:0] read_data;
    logic               is_armed;
    logic               is_done;
  } capture_readout_t;

  class capture_scoreboard;
    lat_cfg_t           cfg;
    lat_phase_e         phase;
    logic [SampleW-1:0] ring [CaptureDepth];
    logic [AddrW-1:0]   wr_ptr;
    logic [AddrW-1:0]   start_pos;
    logic [PreW-1:0]    prefill_cnt;
    logic [PostW-1:0]   post_cnt;
    logic [SampleW-1:0] last_sample;
    logic               last_match;
    logic               baseline_ok;
    capture_readout_t   pending_readouts [$];
    int                 errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      cfg    = '0;
      errors = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      phase       = PH_PREFILL;
      wr_ptr      = '0;
      start_pos   = '0;
      prefill_cnt = '0;
      post_cnt    = '0;
      last_sample = '0;
      last_match  = 1'b0;
      baseline_ok = 1'b0;
    endfunction

    function void set_register(lat_reg_e r, logic [CfgDataW-1:0] v);
      case (r)
        REG_TRIGGER_MODE:  cfg.trigger_mode  = v[ModeW-1:0];
        REG_MATCH_PATTERN: cfg.match_pattern = v[SampleW-1:0];
        REG_MATCH_MASK:    cfg.match_mask    = v[SampleW-1:0];
        REG_EDGE_BIT:      cfg.edge_bit      = v[EdgeW-1:0];
        default: ;
      endcase
    endfunction

    // Trigger decision for one armed sample; mode is taken live from the registers.
    function logic trigger_hit(logic [SampleW-1:0] smp);
      logic hit;
      logic now_match;
      logic prev_bit;
      logic cur_bit;
      hit = 1'b0;
      case (cfg.trigger_mode)
        TRIG_OFF: ;
        TRIG_PATTERN: begin
          now_match = (cfg.match_mask != '0) &&
                      ((smp & cfg.match_mask) == (cfg.match_pattern & cfg.match_mask));
          hit        = now_match && !last_match;
          last_match = now_match;
        end
        default: begin
          prev_bit = last_sample[cfg.edge_bit];
          cur_bit  = smp[cfg.edge_bit];
          if (!baseline_ok) begin
            baseline_ok = 1'b1;
          end else if (cfg.trigger_mode == TRIG_RISE) begin
            hit = !prev_bit && cur_bit;
          end else begin
            hit = prev_bit && !cur_bit;
          end
          last_sample = smp;
        end
      endcase
      return hit;
    endfunction

    function logic store_sample(logic [SampleW-1:0] smp);
      logic hit;
      hit = 1'b0;
      if (phase == PH_DONE) return 1'b0;
      ring[wr_ptr] = smp;
      wr_ptr       = wr_ptr + 1'b1;
      case (phase)
        PH_PREFILL: begin
          prefill_cnt = prefill_cnt + 1'b1;
          if (prefill_cnt >= PreSamples) begin
            last_sample = '0;
            last_match  = 1'b0;
            baseline_ok = 1'b0;
            phase       = PH_ARMED;
          end
        end
        PH_ARMED: begin
          hit = trigger_hit(smp);
          if (hit) begin
            post_cnt = PostW'(PostSamples);
            phase    = PH_POST;
          end
        end
        default: begin
          if (post_cnt != '0) post_cnt = post_cnt - 1'b1;
          if (post_cnt == '0) begin
            start_pos = wr_ptr;
            phase     = PH_DONE;
          end
        end
      endcase
      return hit;
    endfunction

    // Advance the predicted capture by one accepted input and queue its readout.
    function void note_transaction(logic [CmdW-1:0] cmd, logic [SampleW-1:0] smp,
                                   logic [IndexW-1:0] idx);
      capture_readout_t r;
      logic [AddrW-1:0] phys;
      r    = '0;
      phys = start_pos + AddrW'(idx);
      case (cmd)
        CMD_OBSERVE: r.fired = store_sample(smp);
        CMD_READ:    if (phase == PH_DONE) r.read_data = ring[phys];
        CMD_RESTART: clear_capture();
        default: ;
      endcase
      r.is_armed = (phase == PH_ARMED);
      r.is_done  = (phase == PH_DONE);
      pending_readouts.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(logic fired, logic [SampleW-1:0] data, logic armed,
                                logic done);
      capture_readout_t want;
      if (pending_readouts.size() == 0) begin
        $display("%0t: unexpected readout, expected none, %s fired=%0b data=%02h",
                 $time, "actual", fired, data);
        $display("%0t: unexpected readout continued, armed=%0b done=%0b",
                 $time, armed, done);
        errors++;
        return;
      end
      want = pending_readouts.pop_front();
      if ($isunknown({fired, data, armed, done})) begin
        $display("%0t: readout has unknown bits, expected %03h, actual %03h", $time, want,
                 {fired, data, armed, done});
        errors++;
        return;
      end
      compare_field("fired", want.fired, fired);
      compare_field("read_data", want.read_data, data);
      compare_field("is_armed", want.is_armed, armed);
      compare_field("is_done", want.is_done, done);
    endfunction

    // Count recorded mismatches plus predicted readouts that never showed up as failures.
    function int total_failures();
      if (pending_readouts.size() != 0)
        $display("%0t: %0d predicted readouts never arrived", $time, pending_readouts.size());
      return errors + pending_readouts.size();
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Testbench top: drives the trigger capture through several captures and checks each readout.
module tb_top;
  import lat_pkg::*;
  import lat_capture_sb_pkg::*;

  // Cycles without any transaction on either channel before the run is declared hung.
  localparam int StallLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  lat_in_if  in_if ();
  lat_out_if out_if ();

  capture_scoreboard sb;

  // Random back-pressure is switched off for the last part of the run.
  bit calm = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  logic_analyzer_trigger_capture DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Result side: stall in random bursts, change only on the falling edge.
  always @(negedge clk_i) begin
    if (calm) begin
      out_if.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      out_if.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold = $urandom_range(0, 15);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check every readout transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_readout(out_if.fired, out_if.read_data, out_if.is_armed, out_if.is_done);
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one input transaction, possibly after an idle burst, and hold it until taken.
  task automatic push_item(logic [CmdW-1:0] cmd, logic [SampleW-1:0] smp,
                           logic [IndexW-1:0] idx);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.sample_in  <= smp;
    in_if.read_index <= idx;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_transaction(cmd, smp, idx);
  endtask

  // Drop valid, wait for every predicted readout, then let the pipeline empty.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic write_register(lat_reg_e r, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_register(r, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(lat_trig_e mode, logic [SampleW-1:0] pattern,
                           logic [SampleW-1:0] mask, logic [EdgeW-1:0] bit_sel);
    settle();
    write_register(REG_TRIGGER_MODE, CfgDataW'(mode));
    write_register(REG_MATCH_PATTERN, CfgDataW'(pattern));
    write_register(REG_MATCH_MASK, CfgDataW'(mask));
    write_register(REG_EDGE_BIT, CfgDataW'(bit_sel));
  endtask

  // Switch the trigger mode while armed; the block must be drained first.
  task automatic set_mode(lat_trig_e mode);
    settle();
    write_register(REG_TRIGGER_MODE, CfgDataW'(mode));
  endtask

  // Random probe sample; in pattern mode bias toward matches so the trigger fires.
  function automatic logic [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] raw;
    raw = SampleW'($urandom);
    if (sb.cfg.trigger_mode == TRIG_PATTERN && $urandom_range(0, 5) == 0)
      raw = (sb.cfg.match_pattern & sb.cfg.match_mask) | (raw & ~sb.cfg.match_mask);
    return raw;
  endfunction

  // Mostly observes, with reads and no-op commands mixed in; stop at the given phase.
  task automatic capture_traffic(int max_items, lat_phase_e stop_at);
    int roll;
    for (int k = 0; k < max_items && sb.phase != stop_at; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 88)
        push_item(CMD_OBSERVE, pick_sample(), IndexW'($urandom));
      else if (roll < 95)
        push_item(CMD_READ, SampleW'($urandom), IndexW'($urandom));
      else
        push_item(CmdNoOp, SampleW'($urandom), IndexW'($urandom));
    end
  endtask

  // After the capture is done: read it back, and check that observes are ignored.
  task automatic done_readback(int n);
    int roll;
    push_item(CMD_READ, SampleW'($urandom), '0);
    push_item(CMD_READ, SampleW'($urandom), '1);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)
        push_item(CMD_READ, SampleW'($urandom), IndexW'($urandom_range(0, 1023)));
      else if (roll < 85)
        push_item(CMD_OBSERVE, SampleW'($urandom), IndexW'($urandom));
      else
        push_item(CmdNoOp, SampleW'($urandom), IndexW'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_OBSERVE;
    in_if.sample_in  = '0;
    in_if.read_index = '0;
    out_if.ready     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    configure(TRIG_OFF, 8'h00, 8'h00, 3'd0);

    // Directed opening: reads before done return zero, no-op command, restart in prefill.
    push_item(CMD_READ, 8'h00, 10'h000);
    push_item(CMD_READ, 8'hff, 10'h3ff);
    push_item(CmdNoOp, 8'hff, 10'h3ff);
    push_item(CMD_OBSERVE, 8'h00, 10'h000);
    push_item(CMD_OBSERVE, 8'hff, 10'h3ff);
    push_item(CMD_OBSERVE, 8'ha5, 10'h155);
    push_item(CmdNoOp, 8'h00, 10'h000);
    push_item(CMD_RESTART, 8'hff, 10'h3ff);
    push_item(CMD_READ, 8'h5a, 10'h2aa);
    push_item(CMD_OBSERVE, 8'h5a, 10'h2aa);
    push_item(CMD_RESTART, 8'h00, 10'h000);

    // Pattern trigger with the widest pattern and mask.
    configure(TRIG_PATTERN, 8'hff, 8'hff, 3'd7);
    push_item(CMD_RESTART, 8'h00, 10'h000);
    capture_traffic(4000, PH_DONE);
    done_readback(30);

    // Zero mask never matches: stay armed, then hand over to the rising edge on bit 7.
    configure(TRIG_PATTERN, SampleW'($urandom), 8'h00, 3'd7);
    push_item(CMD_RESTART, 8'h00, 10'h000);
    capture_traffic(4000, PH_ARMED);
    capture_traffic(150, PH_DONE);
    set_mode(TRIG_RISE);
    capture_traffic(4000, PH_DONE);
    done_readback(30);

    // Disabled trigger holds the capture armed; then falling edge on bit 0.
    configure(TRIG_OFF, 8'h00, 8'h81, 3'd0);
    push_item(CMD_RESTART, 8'h00, 10'h000);
    capture_traffic(4000, PH_ARMED);
    capture_traffic(150, PH_DONE);
    set_mode(TRIG_FALL);
    capture_traffic(4000, PH_POST);
    // Restart in the middle of the post phase, then run the capture to the end.
    push_item(CMD_RESTART, SampleW'($urandom), IndexW'($urandom));
    capture_traffic(4000, PH_DONE);
    done_readback(30);

    // Last capture: random settings, no idling on either side.
    calm = 1'b1;
    configure(lat_trig_e'($urandom_range(1, 3)), SampleW'($urandom),
              SampleW'($urandom_range(1, 255)), EdgeW'($urandom));
    push_item(CMD_RESTART, 8'h00, 10'h000);
    capture_traffic(4000, PH_DONE);
    done_readback(40);

    settle();
    if (sb.total_failures() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
